// ----- src/nsf_pkg.sv -----
// Shared types, byte codes and decode functions for the NMEA sentence framer.
package nsf_pkg;

    // Longest sentence in bytes; a byte arriving at this position is dropped
    localparam int MAX_SENTENCE = 128;
    localparam int POS_W        = 8;

    // Framing byte codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_BAD_CSUM  = 3'd2,
        ST_BAD_TOL   = 3'd3,
        ST_OVERLEN   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        KIND_NONE = 4'd0,
        KIND_GGA  = 4'd1,
        KIND_VTG  = 4'd2,
        KIND_GLL  = 4'd3,
        KIND_GSA  = 4'd4,
        KIND_GSV  = 4'd5,
        KIND_ZDA  = 4'd6,
        KIND_HDT  = 4'd7,
        KIND_ROT  = 4'd8
    } t_kind;

    typedef struct packed {
        logic       nonprintable_seen;
        logic [6:0] first_field_offset;
        logic [7:0] received_checksum;
        logic [7:0] computed_checksum;
        logic       checksum_present;
        t_kind      sentence_kind;
        logic [7:0] sentence_length;
        t_status    status;
    } t_result;

    // Value of one ASCII hex digit; anything else reads as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [3:0] d;
        d = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) d = b[3:0];
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            d = 4'(b[3:0] + 4'd9);
        return d;
    endfunction

    // Sentence kind from the three letters before the first comma
    function automatic t_kind kind_of_header(input logic        has_comma,
                                             input logic [23:0] hdr);
        t_kind k;
        k = KIND_NONE;
        if (has_comma) begin
            case (hdr)
                24'h474741: k = KIND_GGA;
                24'h565447: k = KIND_VTG;
                24'h474C4C: k = KIND_GLL;
                24'h475341: k = KIND_GSA;
                24'h475356: k = KIND_GSV;
                24'h5A4441: k = KIND_ZDA;
                24'h484454: k = KIND_HDT;
                24'h524F54: k = KIND_ROT;
                default:    k = KIND_NONE;
            endcase
        end
        return k;
    endfunction

endpackage

// ----- src/nmea_sentence_framer_core.sv -----
// Top level of the NMEA 0183 sentence framer: stream ports, config and result register.
//
// Usage: received bytes enter one per word on the slave stream (s_*). Every
// sentence opens with '$' or '!', ends with CR and one more byte (LF when well
// formed); that closing byte yields one result word on the master stream
// (m_*) carrying status and kind in tuser and the sentence figures in tdata.
// Once a sentence holds MAX_SENTENCE bytes, the next byte is dropped with an
// overlength result and the framer restarts with the byte after it. Other
// bytes give no result.
// The result word is registered and appears in the cycle after the closing byte is taken.
// Throughput: one byte per cycle; the single result register keeps taking
// bytes while a result drains, and stalls input only when a result is held
// and the receiver is not ready in the same cycle.
// Reset (synchronous, active low) clears all framing state, the result valid
// flag and the accept_bad_checksum register (checksum mismatch rejected).
// Write accept_bad_checksum through i_cfg_wen / i_cfg_wdata only while no
// sentence is in flight.
module nmea_sentence_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,        // accept_bad_checksum
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,            // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,            // [7:0] sentence_length, [8] checksum_present,
                                            // [16:9] computed_checksum,
                                            // [24:17] received_checksum,
                                            // [31:25] first_field_offset,
                                            // [32] nonprintable_seen, [39:33] zero
    output logic [6:0]  m_tuser             // [2:0] status, [6:3] sentence_kind
);
    import nsf_pkg::*;

    logic    r_accept_bad;
    logic    r_out_valid;
    t_result r_out;
    logic    accept;
    logic    emit;
    t_result result;

    // Take a byte when the result register is free or draining
    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Hold the checksum tolerance setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_bad <= 1'b0;
        end else if (i_cfg_wen) begin
            r_accept_bad <= i_cfg_wdata;
        end
    end

    nsf_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_rx_byte    (s_tdata),
        .i_accept_bad (r_accept_bad),
        .o_emit       (emit),
        .o_result     (result)
    );

    // Load a new result word or drop the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = {r_out.sentence_kind, r_out.status};
    assign m_tdata  = {7'd0, r_out.nonprintable_seen, r_out.first_field_offset,
                       r_out.received_checksum, r_out.computed_checksum,
                       r_out.checksum_present, r_out.sentence_length};

    // Result register empties on reset
    assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // Input is never stalled while the result register is empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Overlength results carry the maximum length and no kind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_out.status == ST_OVERLEN) |->
        (r_out.sentence_length == 8'(MAX_SENTENCE) && r_out.sentence_kind == KIND_NONE))
        else $error("bad overlength result");

    // An ok sentence with a checksum has matching sums
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_out.status == ST_OK && r_out.checksum_present) |->
        (r_out.computed_checksum == r_out.received_checksum))
        else $error("ok status with checksum mismatch");

    // Tolerated mismatch appears only with the setting on
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit && result.status == ST_BAD_TOL) |-> r_accept_bad)
        else $error("tolerated mismatch without setting");

endmodule

// ----- src/nsf_tracker.sv -----
// Per-sentence framing state: position, XOR, comma and star tracking, result build.
module nsf_tracker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_accept_bad,
    output logic           o_emit,
    output nsf_pkg::t_result o_result
);
    import nsf_pkg::*;

    logic [POS_W-1:0] r_pos,       n_pos;
    logic [7:0]       r_xor,       n_xor;
    logic [6:0]       r_comma,     n_comma;
    logic [6:0]       r_star_pos,  n_star_pos;
    logic             r_star_seen, n_star_seen;
    logic             r_cr_seen,   n_cr_seen;
    logic             r_start_bad, n_start_bad;
    logic [7:0]       r_rx_hex,    n_rx_hex;
    logic [23:0]      r_hdr,       n_hdr;
    logic             r_nonprint,  n_nonprint;

    logic [7:0]       hex_val;
    logic [7:0]       star_ext;
    logic             restart;
    logic             malformed;
    t_result          res;

    assign star_ext = {1'b0, r_star_pos};

    // Next state and result for the incoming word
    always_comb begin
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_comma     = r_comma;
        n_star_pos  = r_star_pos;
        n_star_seen = r_star_seen;
        n_cr_seen   = r_cr_seen;
        n_start_bad = r_start_bad;
        n_hdr       = r_hdr;
        n_nonprint  = r_nonprint;
        restart     = 1'b0;
        malformed   = 1'b0;
        o_emit      = 1'b0;

        // Capture checksum digits after the star
        hex_val = r_rx_hex;
        if (r_star_seen) begin
            if (r_pos == 8'(star_ext + 8'd1))
                hex_val = {hex_digit(i_rx_byte), 4'd0};
            else if (r_pos == 8'(star_ext + 8'd2))
                hex_val = r_rx_hex | {4'd0, hex_digit(i_rx_byte)};
        end
        n_rx_hex = hex_val;

        res.status             = ST_OK;
        res.sentence_length    = 8'(r_pos + 8'd1);
        res.sentence_kind      = kind_of_header(r_comma != 7'd0, r_hdr);
        res.checksum_present   = r_star_seen;
        res.computed_checksum  = r_xor;
        res.received_checksum  = hex_val;
        res.first_field_offset = r_comma;
        res.nonprintable_seen  = r_nonprint;

        if (r_pos >= POS_W'(MAX_SENTENCE)) begin
            // Overlength: drop the word, report and restart
            o_emit              = 1'b1;
            restart             = 1'b1;
            res.status          = ST_OVERLEN;
            res.sentence_length = 8'(MAX_SENTENCE);
            res.sentence_kind   = KIND_NONE;
            res.received_checksum = r_rx_hex;
        end else if (r_cr_seen) begin
            // Word after CR closes the sentence
            o_emit    = 1'b1;
            restart   = 1'b1;
            malformed = r_start_bad || (i_rx_byte != CH_LF) ||
                        (r_star_seen && (8'(star_ext + 8'd4) != r_pos));
            if (malformed)
                res.status = ST_MALFORMED;
            else if (r_star_seen && (r_xor != hex_val))
                res.status = i_accept_bad ? ST_BAD_TOL : ST_BAD_CSUM;
        end else begin
            if (r_pos != '0 && !r_star_seen && i_rx_byte != CH_STAR)
                n_xor = r_xor ^ i_rx_byte;

            case (i_rx_byte) inside
                CH_DOLLAR, CH_BANG: begin
                    if (r_pos != '0) n_start_bad = 1'b1;
                end
                CH_COMMA: begin
                    if (r_pos == '0) n_start_bad = 1'b1;
                    else if (r_comma == 7'd0) n_comma = r_pos[6:0];
                end
                CH_STAR: begin
                    if (r_pos == '0) n_start_bad = 1'b1;
                    n_star_pos  = r_pos[6:0];
                    n_star_seen = 1'b1;
                    n_rx_hex    = 8'd0;
                end
                CH_CR: begin
                    if (r_pos == '0) n_start_bad = 1'b1;
                    n_cr_seen = 1'b1;
                end
                default: begin
                    if (r_pos == '0) n_start_bad = 1'b1;
                    if (i_rx_byte < CH_SPACE || i_rx_byte > CH_TILDE) n_nonprint = 1'b1;
                end
            endcase

            // Shift header letters until the first comma is recorded
            if (r_pos != '0 && n_comma == 7'd0)
                n_hdr = {r_hdr[15:0], i_rx_byte};

            n_pos = POS_W'(r_pos + 1'b1);
        end
        o_result = res;
    end

    // Advance state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && restart)) begin
            r_pos       <= '0;
            r_xor       <= '0;
            r_comma     <= '0;
            r_star_pos  <= '0;
            r_star_seen <= 1'b0;
            r_cr_seen   <= 1'b0;
            r_start_bad <= 1'b0;
            r_rx_hex    <= '0;
            r_hdr       <= '0;
            r_nonprint  <= 1'b0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_xor       <= n_xor;
            r_comma     <= n_comma;
            r_star_pos  <= n_star_pos;
            r_star_seen <= n_star_seen;
            r_cr_seen   <= n_cr_seen;
            r_start_bad <= n_start_bad;
            r_rx_hex    <= n_rx_hex;
            r_hdr       <= n_hdr;
            r_nonprint  <= n_nonprint;
        end
    end

endmodule

// ----- tb/tb_nmea_sentence_framer_core.sv -----
// Self-checking stream testbench for the NMEA sentence framer core.
module tb_nmea_sentence_framer_core;
    import nsf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum {CS_NONE, CS_GOOD, CS_BAD} t_csum_mode;

    // Track framing state per received byte and hold the reports it predicts
    class t_sentence_scoreboard;
        bit        tolerate;
        bit [7:0]  pos;
        bit [7:0]  xsum;
        bit [6:0]  comma_at;
        bit [6:0]  star_at;
        bit        star_hit;
        bit        cr_hit;
        bit        start_bad;
        bit [7:0]  rx_hex;
        bit [23:0] hdr;
        bit        unprintable;
        t_result   pending_reports[$];
        int        errors;

        function new();
            tolerate = 1'b0;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            pos         = '0;
            xsum        = '0;
            comma_at    = '0;
            star_at     = '0;
            star_hit    = 1'b0;
            cr_hit      = 1'b0;
            start_bad   = 1'b0;
            rx_hex      = '0;
            hdr         = '0;
            unprintable = 1'b0;
        endfunction

        function void flag(string what);
            if (errors < 10) $display("%s", what);
            errors++;
        endfunction

        function bit [3:0] hex_value(bit [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
            if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 10);
            if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 10);
            return 4'd0;
        endfunction

        function t_kind kind_now();
            if (comma_at == 0) return KIND_NONE;
            case (hdr)
                "GGA":   return KIND_GGA;
                "VTG":   return KIND_VTG;
                "GLL":   return KIND_GLL;
                "GSA":   return KIND_GSA;
                "GSV":   return KIND_GSV;
                "ZDA":   return KIND_ZDA;
                "HDT":   return KIND_HDT;
                "ROT":   return KIND_ROT;
                default: return KIND_NONE;
            endcase
        endfunction

        function void queue_report(t_status st, bit [7:0] len, t_kind k);
            t_result r;
            r.status             = st;
            r.sentence_length    = len;
            r.sentence_kind      = k;
            r.checksum_present   = star_hit;
            r.computed_checksum  = xsum;
            r.received_checksum  = rx_hex;
            r.first_field_offset = comma_at;
            r.nonprintable_seen  = unprintable;
            pending_reports.insert(pending_reports.size(), r);
        endfunction

        // Advance the framer by one accepted byte
        function void note_byte(bit [7:0] b);
            int      p;
            bit      bad;
            t_status st;
            p = pos;
            // Drop the byte at the length limit and restart
            if (p >= MAX_SENTENCE) begin
                queue_report(ST_OVERLEN, 8'(MAX_SENTENCE), KIND_NONE);
                restart();
                return;
            end
            // Collect the two digits after the last star
            if (star_hit) begin
                if (p == star_at + 1)
                    rx_hex = {hex_value(b), 4'h0};
                else if (p == star_at + 2)
                    rx_hex = rx_hex | {4'h0, hex_value(b)};
            end
            // Close the sentence on the byte after CR
            if (cr_hit) begin
                bad = start_bad || b != CH_LF || (star_hit && star_at + 4 != p);
                if (bad)
                    st = ST_MALFORMED;
                else if (star_hit && xsum != rx_hex)
                    st = tolerate ? ST_BAD_TOL : ST_BAD_CSUM;
                else
                    st = ST_OK;
                queue_report(st, 8'(p + 1), kind_now());
                restart();
                return;
            end
            if (p >= 1 && !star_hit && b != CH_STAR) xsum ^= b;
            case (b) inside
                CH_DOLLAR, CH_BANG: begin
                    if (p != 0) start_bad = 1'b1;
                end
                CH_COMMA: begin
                    if (p == 0) start_bad = 1'b1;
                    else if (comma_at == 0) comma_at = p[6:0];
                end
                CH_STAR: begin
                    if (p == 0) start_bad = 1'b1;
                    star_at  = p[6:0];
                    star_hit = 1'b1;
                    rx_hex   = '0;
                end
                CH_CR: begin
                    if (p == 0) start_bad = 1'b1;
                    cr_hit = 1'b1;
                end
                default: begin
                    if (p == 0) start_bad = 1'b1;
                    if (b < CH_SPACE || b > CH_TILDE) unprintable = 1'b1;
                end
            endcase
            if (p >= 1 && comma_at == 0) hdr = {hdr[15:0], b};
            pos = 8'(p + 1);
        endfunction

        function void compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                flag($sformatf("mismatch %s: expected %0h got %0h", name, want, got));
        endfunction

        // Compare one result word with the oldest predicted report
        function void check_report(logic [39:0] d, logic [6:0] u);
            t_result want;
            if (pending_reports.size() == 0) begin
                flag($sformatf("unexpected report: tdata %0h tuser %0h", d, u));
                return;
            end
            want = pending_reports.pop_front();
            compare_field("status", 8'(u[2:0]), 8'(want.status));
            compare_field("sentence_length", d[7:0], want.sentence_length);
            compare_field("sentence_kind", 8'(u[6:3]), 8'(want.sentence_kind));
            compare_field("checksum_present", 8'(d[8]), 8'(want.checksum_present));
            compare_field("computed_checksum", d[16:9], want.computed_checksum);
            compare_field("received_checksum", d[24:17], want.received_checksum);
            compare_field("first_field_offset", 8'(d[31:25]), 8'(want.first_field_offset));
            compare_field("nonprintable_seen", 8'(d[32]), 8'(want.nonprintable_seen));
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wen   = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic [6:0]  m_tuser;

    t_sentence_scoreboard sb = new();
    bit [7:0]    burst_q[$];
    bit [7:0]    frame_xor;
    int          bytes_sent     = 0;
    int          src_gap_pct    = 0;
    int          sink_stall_pct = 0;
    int unsigned cycle_count    = 0;
    string       kind_tags[8]   = '{"GGA", "VTG", "GLL", "GSA", "GSV", "ZDA", "HDT", "ROT"};

    nmea_sentence_framer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every result word taken
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_report(m_tdata, m_tuser);
    end

    // Append one byte to the pending burst
    function automatic void add_byte(bit [7:0] b);
        burst_q.insert(burst_q.size(), b);
    endfunction

    // Build sentences byte by byte, keeping the checksum of the body
    function automatic void open_frame(bit [7:0] lead);
        add_byte(lead);
        frame_xor = '0;
    endfunction

    function automatic void body_byte(bit [7:0] b);
        add_byte(b);
        frame_xor ^= b;
    endfunction

    function automatic void body_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) body_byte(s[i]);
    endfunction

    function automatic void raw_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void end_line();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic bit [7:0] hex_char(bit [3:0] v, bit lc);
        if (v < 10) return 8'(8'h30 + v);
        return 8'((lc ? 8'h61 : 8'h41) + v - 10);
    endfunction

    function automatic void close_frame(t_csum_mode mode, bit lc);
        bit [7:0] sum;
        sum = frame_xor;
        if (mode != CS_NONE) begin
            if (mode == CS_BAD) sum ^= 8'($urandom_range(1, 255));
            add_byte(CH_STAR);
            add_byte(hex_char(sum[7:4], lc));
            add_byte(hex_char(sum[3:0], lc));
        end
        end_line();
    endfunction

    // Offer one byte, idling first at random, and hold it until taken
    task automatic send_byte(bit [7:0] b);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_burst();
        while (burst_q.size() != 0) send_byte(burst_q.pop_front());
    endtask

    // Close any open sentence so that nothing is left in flight
    task automatic flush_sentence();
        while (sb.pos != 0)
            send_byte((sb.cr_hit || sb.pos >= MAX_SENTENCE) ? CH_LF : CH_CR);
    endtask

    task automatic wait_drained();
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Write accept_bad_checksum once the framer has gone quiet
    task automatic set_checksum_tolerance(bit v);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        sb.tolerate = v;
    endtask

    task automatic directed_cases();
        // Well-formed sentences of several kinds, with good, bad and absent checksums
        open_frame(CH_DOLLAR); body_text("GPGGA,123519,4807.038,N"); close_frame(CS_GOOD, 1'b0);
        open_frame(CH_BANG);   body_text("GPVTG,054.7,T");           close_frame(CS_BAD, 1'b0);
        open_frame(CH_DOLLAR); body_text("GPGLL,");                  close_frame(CS_NONE, 1'b0);
        open_frame(CH_DOLLAR); body_text("GPGSV,3,1");               close_frame(CS_GOOD, 1'b1);
        open_frame(CH_DOLLAR); body_text("GPZDA,2");                 close_frame(CS_GOOD, 1'b0);
        open_frame(CH_DOLLAR); body_text("HEHDT,1");                 close_frame(CS_GOOD, 1'b1);
        // No start mark, then a start mark past position 0
        raw_text("GPGSA,1"); end_line();
        raw_text("$GP$SV,2"); end_line();
        // Byte after CR is not LF
        raw_text("$GPZDA,3"); add_byte(CH_CR); add_byte(8'h58);
        // Star only two bytes before CR
        raw_text("$GPHDT*1"); end_line();
        // Comma at position 0
        raw_text(",ROT"); end_line();
        // Control and non-ASCII bytes inside a ROT sentence
        raw_text("$TIROT,");
        add_byte(8'h00); add_byte(8'hFF);
        add_byte(8'h7F); add_byte(8'h1F); add_byte(8'h80);
        end_line();
        // Digits that are not hex read as zero
        raw_text("$AB,1*zz"); end_line();
        // Header shorter than three bytes
        raw_text("$G,1"); end_line();
        // Several stars: the sum stops at the first, digits follow the last
        raw_text("$GPGGA,1*2*41"); end_line();
        // Start mark alone
        raw_text("$"); end_line();
        // Overlength, once plain and once with CR on the last position
        add_byte(CH_DOLLAR);
        repeat (127) add_byte(8'h41);
        add_byte(CH_LF);
        add_byte(CH_DOLLAR);
        repeat (126) add_byte(8'h41);
        end_line();
        send_burst();
    endtask

    task automatic well_formed_frame();
        bit [7:0] c;
        int       r;
        open_frame($urandom_range(3) == 0 ? CH_BANG : CH_DOLLAR);
        repeat (2) body_byte(8'($urandom_range(8'h41, 8'h5A)));
        if ($urandom_range(4) != 0)
            body_text(kind_tags[$urandom_range(7)]);
        else
            repeat (3) body_byte(8'($urandom_range(8'h41, 8'h5A)));
        body_byte(CH_COMMA);
        repeat ($urandom_range(0, 14)) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == CH_DOLLAR || c == CH_BANG || c == CH_STAR) c = CH_COMMA;
            body_byte(c);
        end
        r = $urandom_range(9);
        close_frame(r < 2 ? CS_NONE : (r < 4 ? CS_BAD : CS_GOOD), 1'($urandom_range(1)));
    endtask

    // Mostly well-formed sentences, some broken, some noise, a few overlength
    task automatic random_unit();
        int roll;
        int at;
        roll = $urandom_range(99);
        if (roll < 4) begin
            open_frame(CH_DOLLAR);
            repeat ($urandom_range(127, 135)) body_byte(8'($urandom_range(8'h41, 8'h5A)));
            close_frame(CS_GOOD, 1'b0);
        end else if (roll < 12) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            well_formed_frame();
            if (roll >= 82) begin
                at = $urandom_range(burst_q.size() - 1);
                case ($urandom_range(3))
                    0: burst_q[at] = 8'($urandom_range(0, 255));
                    1: burst_q.delete(at);
                    2: burst_q.insert(at, 8'($urandom_range(0, 255)));
                    default: void'(burst_q.pop_back());
                endcase
            end
        end
        send_burst();
    endtask

    task automatic run_phase(int src_pct, int snk_pct, int budget);
        int start;
        src_gap_pct    = src_pct;
        sink_stall_pct = snk_pct;
        start          = bytes_sent;
        while (bytes_sent - start < budget) random_unit();
        flush_sentence();
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_nmea_sentence_framer_core NOT OK");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_gap_pct    = 34;
        sink_stall_pct = 73;
        directed_cases();
        flush_sentence();
        // Tolerated mismatch once the register is set
        set_checksum_tolerance(1'b1);
        open_frame(CH_DOLLAR); body_text("GPVTG,9"); close_frame(CS_BAD, 1'b0);
        send_burst();
        run_phase(34, 73, 96);
        set_checksum_tolerance(1'b0);
        run_phase(73, 34, 96);
        set_checksum_tolerance(1'b1);
        run_phase(0, 0, 96);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending_reports.size() != 0)
            sb.flag($sformatf("%0d reports never arrived", sb.pending_reports.size()));
        if (sb.errors == 0)
            $display("tb_nmea_sentence_framer_core OK");
        else
            $display("tb_nmea_sentence_framer_core NOT OK");
        $finish;
    end

endmodule
